// File: src/fspe_pkg.sv
// Package: shared types, codes and constants of the flash status poll engine.
`timescale 1ns / 1ps

package fspe_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 20;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_POLL_METHOD  = 2'd0;
  localparam logic [1:0] CFG_EXCEEDED_SUP = 2'd1;
  localparam logic [1:0] CFG_DELAY_TICKS  = 2'd2;

  // Poll methods.
  localparam logic [1:0] METHOD_TOGGLE = 2'd0;
  localparam logic [1:0] METHOD_DATA   = 2'd1;

  // Register reset values.
  localparam logic [1:0] POLL_METHOD_RST  = METHOD_TOGGLE;
  localparam logic       EXCEEDED_SUP_RST = 1'b1;
  localparam logic [9:0] DELAY_TICKS_RST  = 10'd10;

  localparam logic [7:0] BYTE_MASK = 8'hFF;
  localparam int unsigned BIT5 = 5;
  localparam int unsigned BIT6 = 6;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EXCEEDED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FIRST   = 3'd1,
    PH_LOOP    = 3'd2,
    PH_RE1     = 3'd3,
    PH_RE2     = 3'd4,
    PH_FINAL   = 3'd5,
    PH_DELAY   = 3'd6,
    PH_DPFINAL = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  value;
    logic [19:0] time_limit;
  } in_item_t;

  typedef struct packed {
    logic       need_read;
    logic       done_res;
    logic [1:0] status;
    logic       send_reset;
  } out_item_t;

  typedef struct packed {
    logic [1:0] poll_method;
    logic       exceeded_flag_supported;
    logic [9:0] delay_ticks;
  } cfg_t;

endpackage

// File: src/fspe_step.sv
// Next-state and result logic for one transaction of the flash status poll engine.
`timescale 1ns / 1ps

module fspe_step #(
  parameter int unsigned TIME_BITS = fspe_pkg::TIME_BITS_DEFAULT
) (
  input  fspe_pkg::cfg_t         cfg,
  input  fspe_pkg::in_item_t     item,
  input  fspe_pkg::phase_t       phase,
  input  logic [7:0]             expected,
  input  logic [7:0]             prev_read,
  input  logic [TIME_BITS:0]     elapsed,
  input  logic [TIME_BITS-1:0]   limit,
  output fspe_pkg::phase_t       phase_nxt,
  output logic [7:0]             expected_nxt,
  output logic [7:0]             prev_read_nxt,
  output logic [TIME_BITS:0]     elapsed_nxt,
  output logic [TIME_BITS-1:0]   limit_nxt,
  output logic                   res_valid,
  output fspe_pkg::out_item_t    res
);

  localparam int unsigned EW = TIME_BITS + 1;
  localparam int unsigned CW = (EW > 10) ? EW : 10;

  logic          flag;
  logic          data_mode;
  logic          first;
  logic          time_up;
  logic          limit_hit;
  logic [7:0]    prev_sel;
  logic [7:0]    v;
  logic [EW-1:0] elapsed_inc;

  assign v         = item.value;
  assign flag      = cfg.exceeded_flag_supported;
  assign data_mode = (cfg.poll_method == fspe_pkg::METHOD_DATA);
  assign first     = (phase == fspe_pkg::PH_FIRST);
  assign time_up   = elapsed > (EW'(limit) + EW'(1));
  assign limit_hit = flag ? v[fspe_pkg::BIT5] : (!first && time_up);
  assign prev_sel  = first ? (~v & fspe_pkg::BYTE_MASK) : prev_read;
  assign elapsed_inc = (elapsed == {EW{1'b1}}) ? elapsed : elapsed + EW'(1);

  always_comb begin
    phase_nxt     = phase;
    expected_nxt  = expected;
    prev_read_nxt = prev_read;
    elapsed_nxt   = elapsed;
    limit_nxt     = limit;
    res_valid     = 1'b0;
    res           = '0;
    case (item.func)
      fspe_pkg::FUNC_START: begin
        expected_nxt  = v;
        limit_nxt     = TIME_BITS'(item.time_limit);
        elapsed_nxt   = '0;
        prev_read_nxt = '0;
        if (cfg.poll_method inside {fspe_pkg::METHOD_TOGGLE, fspe_pkg::METHOD_DATA}) begin
          phase_nxt     = fspe_pkg::PH_FIRST;
          res_valid     = 1'b1;
          res.need_read = 1'b1;
        end else if (cfg.delay_ticks == '0) begin
          phase_nxt    = fspe_pkg::PH_IDLE;
          res_valid    = 1'b1;
          res.done_res = 1'b1;
          res.status   = fspe_pkg::ST_OK;
        end else begin
          phase_nxt = fspe_pkg::PH_DELAY;
        end
      end
      fspe_pkg::FUNC_READ: begin
        case (phase)
          fspe_pkg::PH_FIRST, fspe_pkg::PH_LOOP: begin
            prev_read_nxt = v;
            res_valid     = 1'b1;
            if (data_mode) begin
              if (limit_hit) begin
                phase_nxt     = fspe_pkg::PH_DPFINAL;
                res.need_read = 1'b1;
              end else if (v == expected) begin
                phase_nxt    = fspe_pkg::PH_IDLE;
                res.done_res = 1'b1;
                res.status   = fspe_pkg::ST_OK;
              end else begin
                phase_nxt     = fspe_pkg::PH_LOOP;
                res.need_read = 1'b1;
              end
            end else begin
              res.need_read = 1'b1;
              if (limit_hit) begin
                phase_nxt = fspe_pkg::PH_RE1;
              end else if (prev_sel[fspe_pkg::BIT6] == v[fspe_pkg::BIT6]) begin
                phase_nxt = fspe_pkg::PH_FINAL;
              end else begin
                phase_nxt = fspe_pkg::PH_LOOP;
              end
            end
          end
          fspe_pkg::PH_RE1: begin
            prev_read_nxt = v;
            phase_nxt     = fspe_pkg::PH_RE2;
            res_valid     = 1'b1;
            res.need_read = 1'b1;
          end
          fspe_pkg::PH_RE2: begin
            prev_read_nxt = v;
            res_valid     = 1'b1;
            if (prev_read[fspe_pkg::BIT6] == v[fspe_pkg::BIT6]) begin
              phase_nxt     = fspe_pkg::PH_FINAL;
              res.need_read = 1'b1;
            end else begin
              phase_nxt      = fspe_pkg::PH_IDLE;
              res.done_res   = 1'b1;
              res.status     = fspe_pkg::ST_EXCEEDED;
              res.send_reset = 1'b1;
            end
          end
          fspe_pkg::PH_FINAL: begin
            prev_read_nxt = v;
            phase_nxt     = fspe_pkg::PH_IDLE;
            res_valid     = 1'b1;
            res.done_res  = 1'b1;
            res.status    = (v == expected) ? fspe_pkg::ST_OK : fspe_pkg::ST_MISMATCH;
          end
          fspe_pkg::PH_DPFINAL: begin
            prev_read_nxt = v;
            phase_nxt     = fspe_pkg::PH_IDLE;
            res_valid     = 1'b1;
            res.done_res  = 1'b1;
            if (v == expected) begin
              res.status = fspe_pkg::ST_OK;
            end else begin
              res.status     = fspe_pkg::ST_EXCEEDED;
              res.send_reset = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      fspe_pkg::FUNC_TICK: begin
        if (phase != fspe_pkg::PH_IDLE) begin
          elapsed_nxt = elapsed_inc;
          if (phase == fspe_pkg::PH_DELAY &&
              CW'(elapsed_inc) >= CW'(cfg.delay_ticks)) begin
            phase_nxt    = fspe_pkg::PH_IDLE;
            res_valid    = 1'b1;
            res.done_res = 1'b1;
            res.status   = fspe_pkg::ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/flash_status_poll_engine_unit.sv
// Top level of the flash status poll engine: registers, handshakes and configuration.
`timescale 1ns / 1ps

// The flash status poll engine watches a parallel NOR flash through a program or
// erase operation. A start transaction loads the expected final byte and a time
// limit in milliseconds; read transactions then carry status bytes read from the
// chip and tick transactions mark each elapsed millisecond. In toggle mode the
// wait ends once status bit 6 reads the same twice in a row, after which a final
// read is compared with the expected byte; in data-polling mode it ends when a
// read equals the expected byte; fixed-delay mode reports success after the set
// number of ticks. A time limit, flagged by the chip on bit 5 or counted from the
// ticks, ends the wait early and leads to rereads, and an exceeded result also
// asks for a chip reset. The block accepts one transaction per clock, the
// next-state logic sitting between the state registers and a single result
// register. The input is stalled only while that result register holds a
// result that the output side is stalling. Transactions that produce no result
// leave the output untouched. Configuration writes are always taken (cfg_ready
// is tied high) and should be made only while no wait is in progress; an
// unknown register index is ignored.

module flash_status_poll_engine_unit #(
  parameter int unsigned TIME_BITS = fspe_pkg::TIME_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fspe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fspe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data
);

  // Configuration registers.
  fspe_pkg::cfg_t cfg_r;

  // Poll state.
  fspe_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]           expected_r, expected_nxt;
  logic [7:0]           prev_read_r, prev_read_nxt;
  logic [TIME_BITS:0]   elapsed_r, elapsed_nxt;
  logic [TIME_BITS-1:0] limit_r, limit_nxt;

  // Result register.
  logic                out_valid_r;
  fspe_pkg::out_item_t out_data_r;

  logic                res_valid;
  fspe_pkg::out_item_t res;
  logic                in_accept;
  logic                out_free;

  assign cfg_ready = 1'b1;

  // The result register can take a new value when empty or being emptied.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !out_free;
  assign in_accept = in_valid && out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_method             <= fspe_pkg::POLL_METHOD_RST;
      cfg_r.exceeded_flag_supported <= fspe_pkg::EXCEEDED_SUP_RST;
      cfg_r.delay_ticks             <= fspe_pkg::DELAY_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fspe_pkg::CFG_POLL_METHOD:  cfg_r.poll_method             <= cfg_data[1:0];
        fspe_pkg::CFG_EXCEEDED_SUP: cfg_r.exceeded_flag_supported <= cfg_data[0];
        fspe_pkg::CFG_DELAY_TICKS:  cfg_r.delay_ticks             <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fspe_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cfg           (cfg_r),
    .item          (in_data),
    .phase         (phase_r),
    .expected      (expected_r),
    .prev_read     (prev_read_r),
    .elapsed       (elapsed_r),
    .limit         (limit_r),
    .phase_nxt     (phase_nxt),
    .expected_nxt  (expected_nxt),
    .prev_read_nxt (prev_read_nxt),
    .elapsed_nxt   (elapsed_nxt),
    .limit_nxt     (limit_nxt),
    .res_valid     (res_valid),
    .res           (res)
  );

  // The poll state is architectural and follows the reset of the behaviour.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fspe_pkg::PH_IDLE;
      expected_r  <= '0;
      prev_read_r <= '0;
      elapsed_r   <= '0;
      limit_r     <= '0;
    end else if (in_accept) begin
      phase_r     <= phase_nxt;
      expected_r  <= expected_nxt;
      prev_read_r <= prev_read_nxt;
      elapsed_r   <= elapsed_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_accept && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

// File: sim/flash_status_poll_engine_unit_test.sv
// Self-checking testbench for the flash status poll engine unit.
`timescale 1ns / 1ps

// The testbench drives start, status-read and tick transactions into the poll
// engine and checks every result against a cycle-free predictor of the poller
// kept here. The predictor runs at the clock edge where a transaction is
// accepted, so its state always matches what the block has seen. The expected
// results wait in a queue. The monitor compares each accepted result with the
// oldest entry, field by field.
//
// The stimulus opens with a short directed part. That part covers the toggle
// exit, the final compare, rereads after the chip flags its time limit, the
// exceeded ending after the rereads, and a limit counted from the ticks in
// data-polling mode. It also covers transactions that are ignored while idle,
// the unused function code and a start that abandons a wait. After that comes
// a random part built from imitated chip behaviour: a start, then a busy stretch
// in which bit 6 toggles and bit 7 is inverted, then the settled byte (now and
// then a corrupted one), with ticks in between. This is run under several
// register settings, a zero delay and a long one among them. Inputs change on the
// falling clock edge and everything is sampled on the rising edge.

module flash_status_poll_engine_unit_test;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] METHOD_DELAY = 2'd2;
  localparam logic [1:0] METHOD_SPARE = 2'd3;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;
  localparam logic [1:0] CFG_SPARE    = 2'd3;
  localparam int         NUM_PLANS    = 10;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fspe_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  fspe_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [9:0]          cfg_data;

  flash_status_poll_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state. The register copies start at their reset values, and the
  // poller state starts idle.
  logic [1:0]        m_method  = fspe_pkg::POLL_METHOD_RST;
  logic              m_flag    = fspe_pkg::EXCEEDED_SUP_RST;
  logic [9:0]        m_delay   = fspe_pkg::DELAY_TICKS_RST;
  fspe_pkg::phase_t  m_phase   = fspe_pkg::PH_IDLE;
  logic [7:0]        m_want    = '0;
  logic [7:0]        m_prev    = '0;
  logic [20:0]       m_elapsed = '0;
  logic [19:0]       m_limit   = '0;

  fspe_pkg::in_item_t  chip_traffic [$];   // transactions waiting to be driven
  fspe_pkg::out_item_t awaited [$];        // results predicted but not yet seen

  int  errors = 0;
  int  queued = 0;
  int  accepted = 0;
  int  checked = 0;
  int  reg_writes = 0;
  int  n_ok = 0;
  int  n_mismatch = 0;
  int  n_exceeded = 0;
  int  n_reread = 0;

  // Handshake flags seen at the rising edge, read by the processes at the falling edge.
  logic in_took = 1'b0;
  logic cfg_took = 1'b0;

  // Idling state of both sides. A calm stretch switches the gaps and the output stalls off for a while.
  bit  calm = 1'b0;
  int  calm_left = 0;
  int  burst_left = 8;
  int  gap_left = 0;
  bit  drain_hold = 1'b0;
  int  stall_run = 0;
  int  free_run = 0;

  // Works out what the poller does with one transaction. It returns 1 when a
  // result is produced, and that result is then placed in r.
  function automatic bit advance_poller(input fspe_pkg::in_item_t it,
                                        output fspe_pkg::out_item_t r);
    logic [7:0]        v;
    logic [7:0]        prv;
    bit                first;
    bit                lim;
    bit                fin;
    fspe_pkg::status_t st;
    r   = '0;
    v   = it.value;
    fin = 1'b0;
    st  = fspe_pkg::ST_OK;
    case (it.func)
      fspe_pkg::FUNC_START: begin
        m_want    = v;
        m_limit   = it.time_limit;
        m_elapsed = '0;
        m_prev    = '0;
        if (m_method == fspe_pkg::METHOD_TOGGLE || m_method == fspe_pkg::METHOD_DATA) begin
          m_phase     = fspe_pkg::PH_FIRST;
          r.need_read = 1'b1;
          return 1'b1;
        end
        // Fixed delay, and the spare method code with it.
        m_phase = fspe_pkg::PH_DELAY;
        if (m_delay != 0) begin
          return 1'b0;
        end
        m_phase    = fspe_pkg::PH_IDLE;
        r.done_res = 1'b1;
        r.status   = fspe_pkg::ST_OK;
        return 1'b1;
      end
      fspe_pkg::FUNC_READ: begin
        case (m_phase)
          fspe_pkg::PH_FIRST, fspe_pkg::PH_LOOP: begin
            first = (m_phase == fspe_pkg::PH_FIRST);
            // Without the chip flag the limit is counted from ticks, and never at
            // the first read.
            lim = m_flag ? v[fspe_pkg::BIT5]
                         : (!first && m_elapsed > {1'b0, m_limit} + 21'd1);
            prv = first ? ~v : m_prev;
            m_prev = v;
            if (m_method == fspe_pkg::METHOD_DATA) begin
              if (lim) begin
                m_phase = fspe_pkg::PH_DPFINAL;
              end else if (v == m_want) begin
                fin = 1'b1;
              end else begin
                m_phase = fspe_pkg::PH_LOOP;
              end
            end else if (lim) begin
              m_phase = fspe_pkg::PH_RE1;
            end else if (prv[fspe_pkg::BIT6] == v[fspe_pkg::BIT6]) begin
              m_phase = fspe_pkg::PH_FINAL;
            end else begin
              m_phase = fspe_pkg::PH_LOOP;
            end
          end
          fspe_pkg::PH_RE1: begin
            m_prev  = v;
            m_phase = fspe_pkg::PH_RE2;
          end
          fspe_pkg::PH_RE2: begin
            prv    = m_prev;
            m_prev = v;
            if (prv[fspe_pkg::BIT6] == v[fspe_pkg::BIT6]) begin
              m_phase = fspe_pkg::PH_FINAL;
            end else begin
              fin = 1'b1;
              st  = fspe_pkg::ST_EXCEEDED;
            end
          end
          fspe_pkg::PH_FINAL: begin
            m_prev = v;
            fin    = 1'b1;
            st     = (v == m_want) ? fspe_pkg::ST_OK : fspe_pkg::ST_MISMATCH;
          end
          fspe_pkg::PH_DPFINAL: begin
            m_prev = v;
            fin    = 1'b1;
            st     = (v == m_want) ? fspe_pkg::ST_OK : fspe_pkg::ST_EXCEEDED;
          end
          default: begin
            return 1'b0;
          end
        endcase
        if (fin) begin
          m_phase      = fspe_pkg::PH_IDLE;
          r.done_res   = 1'b1;
          r.status     = st;
          r.send_reset = (st == fspe_pkg::ST_EXCEEDED);
        end else begin
          r.need_read = 1'b1;
        end
        return 1'b1;
      end
      fspe_pkg::FUNC_TICK: begin
        if (m_phase == fspe_pkg::PH_IDLE) begin
          return 1'b0;
        end
        if (m_elapsed != '1) begin
          m_elapsed = m_elapsed + 21'd1;
        end
        if (m_phase == fspe_pkg::PH_DELAY && m_elapsed >= {11'd0, m_delay}) begin
          m_phase    = fspe_pkg::PH_IDLE;
          r.done_res = 1'b1;
          r.status   = fspe_pkg::ST_OK;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Monitor. Results are checked before the transaction accepted at the same edge
  // is predicted. That result can only come from an earlier transaction, so this
  // order is safe.
  always @(posedge clk) begin
    fspe_pkg::out_item_t got;
    fspe_pkg::out_item_t want;
    fspe_pkg::out_item_t fresh;
    in_took  <= rst_n && in_valid && !in_stall;
    cfg_took <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (awaited.size() == 0) begin
          $error("result with nothing expected: need_read %0d done_res %0d status %0d",
                 got.need_read, got.done_res, got.status);
          errors++;
        end else begin
          want = awaited.pop_front();
          checked++;
          check_field("need_read", {1'b0, want.need_read}, {1'b0, got.need_read});
          check_field("done_res", {1'b0, want.done_res}, {1'b0, got.done_res});
          check_field("status", want.status, got.status);
          check_field("send_reset", {1'b0, want.send_reset}, {1'b0, got.send_reset});
          if (want.need_read) begin
            n_reread++;
          end else if (want.status == fspe_pkg::ST_OK) begin
            n_ok++;
          end else if (want.status == fspe_pkg::ST_MISMATCH) begin
            n_mismatch++;
          end else begin
            n_exceeded++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          fspe_pkg::CFG_POLL_METHOD:  m_method = cfg_data[1:0];
          fspe_pkg::CFG_EXCEEDED_SUP: m_flag   = cfg_data[0];
          fspe_pkg::CFG_DELAY_TICKS:  m_delay  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        accepted++;
        if (advance_poller(in_data, fresh)) begin
          awaited.push_back(fresh);
        end
      end
    end
  end

  // Calm stretches come and go on their own timer. They are updated at the rising
  // edge so that both drivers read a settled value at the falling edge.
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(50, 300);
    end else begin
      calm_left--;
    end
  end

  // Sender. It works in bursts with gaps between them. Now and then it holds back
  // until every outstanding result has come out. A presented transaction stays put
  // until it is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (drain_hold && awaited.size() != 0) begin
        in_valid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (chip_traffic.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_data    <= chip_traffic.pop_front();
        in_valid   <= 1'b1;
        drain_hold = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          if (calm) begin
            gap_left = 0;
          end else if ($urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(4, 20);
          end else begin
            gap_left = $urandom_range(0, 3);
          end
          if ($urandom_range(0, 39) == 0) begin
            drain_hold = 1'b1;
          end
        end
      end
    end
  end

  // Receiver. It alternates runs of stall with runs of free flow.
  always @(negedge clk) begin
    if (rst_n) begin
      if (calm) begin
        stall_run = 0;
        out_stall <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (free_run > 0) begin
        free_run--;
        out_stall <= 1'b0;
      end else begin
        stall_run = $urandom_range(0, 7);
        free_run  = $urandom_range(0, 12);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_item(input logic [1:0] f, input logic [7:0] v, input logic [19:0] lim);
    fspe_pkg::in_item_t it;
    it.func       = f;
    it.value      = v;
    it.time_limit = lim;
    chip_traffic.push_back(it);
    queued++;
  endtask

  // Queues one wait as a chip would produce it. The reads during the busy stretch
  // toggle bit 6, invert bit 7 and sometimes raise bit 5. After that the chip
  // returns the programmed byte, or now and then a wrong one. Some waits are cut
  // short so that the next start abandons them.
  task automatic queue_chip_wait(input fspe_pkg::cfg_t c);
    logic [7:0]  want;
    logic [7:0]  rd;
    logic [19:0] lim;
    int          busy;
    int          steps;
    int          k;
    int          waits;
    bit          tog;
    bit          timed;
    timed = !(c.poll_method == fspe_pkg::METHOD_TOGGLE ||
              c.poll_method == fspe_pkg::METHOD_DATA);
    case ($urandom_range(0, 7))
      0:       want = 8'h00;
      1:       want = fspe_pkg::BYTE_MASK;
      default: want = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: lim = 20'($urandom_range(0, 4));
      6, 7:             lim = 20'($urandom_range(5, 40));
      8:                lim = '1;
      default:          lim = 20'($urandom);
    endcase
    add_item(fspe_pkg::FUNC_START, want, lim);
    if (timed) begin
      if ($urandom_range(0, 9) == 0) begin
        steps = $urandom_range(0, c.delay_ticks);
      end else begin
        steps = c.delay_ticks + $urandom_range(0, 2);
      end
      for (k = 0; k < steps; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          add_item(fspe_pkg::FUNC_READ, 8'($urandom), 20'($urandom));
        end
        add_item(fspe_pkg::FUNC_TICK, 8'($urandom), 20'($urandom));
      end
    end else begin
      busy  = $urandom_range(0, 8);
      tog   = 1'($urandom_range(0, 1));
      steps = busy + $urandom_range(0, 4);
      for (k = 0; k < steps; k++) begin
        waits = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        repeat (waits) add_item(fspe_pkg::FUNC_TICK, 8'($urandom), 20'($urandom));
        if ($urandom_range(0, 24) == 0) begin
          add_item(FUNC_SPARE, 8'($urandom), 20'($urandom));
        end
        if (k < busy) begin
          rd                 = 8'($urandom);
          rd[fspe_pkg::BIT6] = tog;
          rd[7]              = ~want[7];
          rd[fspe_pkg::BIT5] = ($urandom_range(0, 5) == 0);
          tog                = ~tog;
        end else if ($urandom_range(0, 5) == 0) begin
          rd = 8'($urandom);
        end else begin
          rd = want;
        end
        add_item(fspe_pkg::FUNC_READ, rd, 20'($urandom));
      end
    end
  endtask

  // Waits until nothing is queued, in flight or outstanding. It then gives the
  // result register time to settle, since the last transaction may have produced
  // no result. The task returns at a falling edge.
  task automatic settle();
    while (chip_traffic.size() != 0 || in_valid || awaited.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // One register write. The valid stays high into the next write, so each edge
  // sees only one assignment to it.
  task automatic cfg_put(input logic [1:0] idx, input logic [9:0] d, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    while (!cfg_took) begin
      @(negedge clk);
    end
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic load_settings(input fspe_pkg::cfg_t c);
    cfg_put(fspe_pkg::CFG_POLL_METHOD, {8'd0, c.poll_method}, 1'b0);
    cfg_put(fspe_pkg::CFG_EXCEEDED_SUP, {9'd0, c.exceeded_flag_supported}, 1'b0);
    cfg_put(fspe_pkg::CFG_DELAY_TICKS, c.delay_ticks, 1'b1);
  endtask

  initial begin
    fspe_pkg::cfg_t plan [NUM_PLANS];
    int             budget [NUM_PLANS];
    int             p;
    int             mark;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // Register settings for the random part, with the number of transactions for
    // each. The long delay takes a single wait only, because every tick of it is
    // a transaction.
    plan[0] = '{fspe_pkg::METHOD_TOGGLE, 1'b1, 10'd10};   budget[0] = 55;
    plan[1] = '{fspe_pkg::METHOD_TOGGLE, 1'b0, 10'd10};   budget[1] = 55;
    plan[2] = '{fspe_pkg::METHOD_DATA,   1'b1, 10'd0};    budget[2] = 55;
    plan[3] = '{fspe_pkg::METHOD_DATA,   1'b0, 10'd1023}; budget[3] = 55;
    plan[4] = '{METHOD_DELAY,            1'b1, 10'd0};    budget[4] = 30;
    plan[5] = '{METHOD_DELAY,            1'b0, 10'd3};    budget[5] = 40;
    plan[6] = '{METHOD_SPARE,            1'b1, 10'd1};    budget[6] = 30;
    plan[7] = '{METHOD_DELAY,            1'b1, 10'd200};  budget[7] = 1;
    plan[8] = '{fspe_pkg::METHOD_TOGGLE, 1'b0, 10'd5};    budget[8] = 55;
    plan[9] = '{fspe_pkg::METHOD_DATA,   1'b1, 10'd7};    budget[9] = 55;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings, which are toggle mode with the chip flag.
    // First, a clean toggle exit and a matching final read.
    add_item(fspe_pkg::FUNC_START, 8'h00, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h00, 20'hFFFFF);
    add_item(fspe_pkg::FUNC_READ, 8'h00, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h00, 20'h00000);
    // The chip flags its limit on the first read, and the rereads still toggle.
    add_item(fspe_pkg::FUNC_START, 8'hFF, 20'hFFFFF);
    add_item(fspe_pkg::FUNC_READ, 8'h20, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h40, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h00, 20'h00000);
    // The limit is flagged on the first read again and the rereads toggle.
    add_item(fspe_pkg::FUNC_START, 8'h5A, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'hFF, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'hBF, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h5A, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h5A, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h00, 20'h00000);
    // These are ignored while idle, and so is the unused function code.
    add_item(fspe_pkg::FUNC_TICK, 8'hFF, 20'hFFFFF);
    add_item(fspe_pkg::FUNC_READ, 8'hFF, 20'hFFFFF);
    add_item(FUNC_SPARE, 8'hFF, 20'hFFFFF);
    // A start abandons a wait. The second wait is left open, so the method changes
    // under it.
    add_item(fspe_pkg::FUNC_START, 8'h11, 20'h00003);
    add_item(fspe_pkg::FUNC_START, 8'h80, 20'h00000);
    settle();

    // Data polling with the limit counted from ticks. A write to an unknown index
    // goes first, and it must change nothing.
    cfg_put(CFG_SPARE, 10'($urandom), 1'b0);
    load_settings('{fspe_pkg::METHOD_DATA, 1'b0, 10'd10});
    add_item(fspe_pkg::FUNC_START, 8'h80, 20'h00000);
    add_item(fspe_pkg::FUNC_TICK, 8'h00, 20'h00000);
    add_item(fspe_pkg::FUNC_TICK, 8'h00, 20'h00000);
    add_item(fspe_pkg::FUNC_TICK, 8'h00, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h00, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h00, 20'h00000);
    add_item(fspe_pkg::FUNC_READ, 8'h80, 20'h00000);

    // Random part, one register setting after another.
    for (p = 0; p < NUM_PLANS; p++) begin
      settle();
      load_settings(plan[p]);
      mark = queued;
      while (queued - mark < budget[p]) begin
        queue_chip_wait(plan[p]);
      end
    end
    settle();

    $display("Drove %0d transactions through %0d register writes; %0d results checked.",
             accepted, reg_writes, checked);
    $display("Outcomes: %0d read requests, %0d success, %0d mismatch, %0d exceeded.",
             n_reread, n_ok, n_mismatch, n_exceeded);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
src/fspe_pkg.sv
src/fspe_step.sv
src/flash_status_poll_engine_unit.sv
sim/flash_status_poll_engine_unit_test.sv
